### hdl/ppa_pkg.sv
// shared types, constants and sizes of the progressive pixel accumulator
package ppa_pkg;

   localparam int unsigned PIXELS       = 65536;
   localparam int unsigned CHANNEL_BITS = 16;

   localparam int unsigned INDEX_BITS   = 16;
   localparam int unsigned SAMPLE_BITS  = 16;
   localparam int unsigned COUNT_BITS   = 16;
   localparam int unsigned DIVISOR_BITS = COUNT_BITS + 1;
   localparam int unsigned BYTE_BITS    = 8;
   localparam int unsigned RGB_BITS     = 24;
   localparam int unsigned CHANNELS     = 3;

   localparam int unsigned CH_RED   = 0;
   localparam int unsigned CH_GREEN = 1;
   localparam int unsigned CH_BLUE  = 2;

   localparam int unsigned STORE_DEPTH = (PIXELS > (1 << INDEX_BITS)) ? (1 << INDEX_BITS) : PIXELS;
   localparam int unsigned STORE_ADDR_BITS = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
   localparam int unsigned STORE_BITS = CHANNELS * CHANNEL_BITS;

   localparam int unsigned CLAMP_Q     = 4091;
   localparam int unsigned CLAMP_BITS  = 12;
   localparam int unsigned SCALE_Q     = 1048572;
   localparam int unsigned SCALE_BITS  = 20;
   localparam int unsigned SCALE_SHIFT = 24;
   localparam int unsigned PROD_BITS   = CLAMP_BITS + SCALE_BITS;

   typedef logic [CHANNELS-1:0][CHANNEL_BITS-1:0] chan_vec_type;

   typedef struct packed {
      logic [INDEX_BITS-1:0]  pixel_index;
      logic [SAMPLE_BITS-1:0] sample_red;
      logic [SAMPLE_BITS-1:0] sample_green;
      logic [SAMPLE_BITS-1:0] sample_blue;
      logic [COUNT_BITS-1:0]  frame_count;
   } req_type;

   typedef struct packed {
      logic [INDEX_BITS-1:0] out_index;
      logic [RGB_BITS-1:0]   packed_rgb;
   } rsp_type;

   typedef struct packed {
      logic [INDEX_BITS-1:0]   idx;
      chan_vec_type            sample;
      logic [COUNT_BITS-1:0]   count;
      logic [DIVISOR_BITS-1:0] divisor;
      logic                    in_range;
      logic                    need_read;
   } item_type;

   typedef struct packed {
      logic     valid;
      item_type item;
   } queue_head_type;

endpackage

### hdl/ppa_ram.sv
// generic single write port, single read port ram with registered read
module ppa_ram #(
   parameter int unsigned WIDTH = 8,
   parameter int unsigned DEPTH = 2
) (
   input  logic                                       clock,
   input  logic                                       we,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
   input  logic [WIDTH-1:0]                           wdata,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
   output logic [WIDTH-1:0]                           rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

### hdl/ppa_front.sv
// front end: accepts samples, classifies them and queues them for the back end
module ppa_front import ppa_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   input  logic           push,
   output logic           full,
   input  req_type        req_data,
   output queue_head_type head,
   input  logic           head_pop
);

   localparam int unsigned QUEUE_DEPTH = 4;
   localparam int unsigned QPTR_BITS   = $clog2(QUEUE_DEPTH);
   localparam int unsigned QCNT_BITS   = QPTR_BITS + 1;

   item_type               queue_ff [QUEUE_DEPTH];
   logic [QPTR_BITS-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QPTR_BITS-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QCNT_BITS-1:0]   count_ff, count_in;
   item_type               item;
   logic                   take;
   logic                   give;

   function automatic logic [CHANNEL_BITS-1:0] to_chan(input logic [SAMPLE_BITS-1:0] s);
      logic [63:0] wide;
      wide = 64'(s);
      return wide[CHANNEL_BITS-1:0];
   endfunction

   always_comb begin
      item.idx              = req_data.pixel_index;
      item.sample[CH_RED]   = to_chan(req_data.sample_red);
      item.sample[CH_GREEN] = to_chan(req_data.sample_green);
      item.sample[CH_BLUE]  = to_chan(req_data.sample_blue);
      item.count            = req_data.frame_count;
      item.divisor          = DIVISOR_BITS'(req_data.frame_count) + DIVISOR_BITS'(1);
      item.in_range         = 32'(req_data.pixel_index) < PIXELS;
      item.need_read        = item.in_range && (req_data.frame_count != '0);
   end

   assign full = count_ff == QCNT_BITS'(QUEUE_DEPTH);
   assign take = push && !full;
   assign give = head_pop && (count_ff != '0);

   assign wr_ptr_in = take ? wr_ptr_ff + QPTR_BITS'(1) : wr_ptr_ff;
   assign rd_ptr_in = give ? rd_ptr_ff + QPTR_BITS'(1) : rd_ptr_ff;
   assign count_in  = count_ff + QCNT_BITS'(take) - QCNT_BITS'(give);

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         queue_ff[wr_ptr_ff] <= item;
      end
   end

   assign head.valid = count_ff != '0;
   assign head.item  = queue_ff[rd_ptr_ff];

endmodule

### hdl/ppa_back.sv
// back end: store read, multiply, pipelined divide, write back, quantize and result queue
module ppa_back import ppa_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   input  queue_head_type head,
   output logic           head_pop,
   output logic           empty,
   input  logic           pop,
   output rsp_type        rsp_data
);

   localparam int unsigned OUT_DEPTH = 32;
   localparam int unsigned OPTR_BITS = $clog2(OUT_DEPTH);
   localparam int unsigned OCNT_BITS = OPTR_BITS + 1;
   localparam int unsigned SUM_BITS  = CHANNEL_BITS + COUNT_BITS;
   localparam int unsigned REM_BITS  = COUNT_BITS;
   localparam int unsigned STEPS     = CHANNEL_BITS;

   typedef struct packed {
      logic [INDEX_BITS-1:0]   idx;
      logic                    in_range;
      logic [DIVISOR_BITS-1:0] divisor;
   } meta_type;

   typedef logic [CHANNELS-1:0][REM_BITS-1:0]  rem_vec_type;
   typedef logic [CHANNELS-1:0][REM_BITS:0]    step_vec_type;
   typedef logic [CHANNELS-1:0][SUM_BITS-1:0]  sum_vec_type;
   typedef logic [CHANNELS-1:0][PROD_BITS-1:0] prod_vec_type;

   logic         s1_valid_ff;
   item_type     s1_item_ff;
   logic         s2_valid_ff;
   meta_type     s2_meta_ff;
   chan_vec_type s2_sample_ff;
   sum_vec_type  s2_prod_ff, s2_prod_in;

   logic         dv_valid_ff [STEPS+1];
   meta_type     dv_meta_ff  [STEPS+1];
   rem_vec_type  dv_rem_ff   [STEPS+1];
   chan_vec_type dv_quot_ff  [STEPS+1];
   step_vec_type dv_step_in  [STEPS+1];
   sum_vec_type  dv_sum_in;

   logic                  q_valid_ff;
   logic [INDEX_BITS-1:0] q_idx_ff;
   prod_vec_type          q_prod_ff, q_prod_in;

   rsp_type              out_ff [OUT_DEPTH];
   rsp_type              out_entry;
   logic [OPTR_BITS-1:0] out_wr_ff, out_wr_in;
   logic [OPTR_BITS-1:0] out_rd_ff, out_rd_in;
   logic [OCNT_BITS-1:0] out_count_ff, out_count_in;
   logic [OCNT_BITS-1:0] reserved_ff, reserved_in;
   logic                 out_take;

   chan_vec_type store_rdata;
   chan_vec_type stored;
   logic         match;
   logic         issue;

   function automatic logic [REM_BITS:0] div_step(input logic [REM_BITS-1:0] rem,
                                                 input logic nbit,
                                                 input logic [DIVISOR_BITS-1:0] divisor);
      logic [REM_BITS:0] trial;
      logic [REM_BITS:0] diff;
      trial = {rem, nbit};
      diff  = trial - divisor;
      if (trial >= divisor) begin
         return {diff[REM_BITS-1:0], 1'b1};
      end
      return {rem[REM_BITS-2:0], nbit, 1'b0};
   endfunction

   // hazard: a reading sample waits for any older in-flight write to the same pixel
   always_comb begin
      match = (s1_valid_ff && s1_item_ff.in_range && (s1_item_ff.idx == head.item.idx))
           || (s2_valid_ff && s2_meta_ff.in_range && (s2_meta_ff.idx == head.item.idx));
      for (int k = 0; k <= STEPS; k++) begin
         match = match || (dv_valid_ff[k] && dv_meta_ff[k].in_range
                           && (dv_meta_ff[k].idx == head.item.idx));
      end
   end

   assign issue    = head.valid && !(head.item.need_read && match)
                     && (reserved_ff < OCNT_BITS'(OUT_DEPTH));
   assign head_pop = issue;

   ppa_ram #(
      .WIDTH (STORE_BITS),
      .DEPTH (STORE_DEPTH)
   ) u_store (
      .clock (clock),
      .we    (dv_valid_ff[STEPS] && dv_meta_ff[STEPS].in_range),
      .waddr (dv_meta_ff[STEPS].idx[STORE_ADDR_BITS-1:0]),
      .wdata (dv_quot_ff[STEPS]),
      .raddr (head.item.idx[STORE_ADDR_BITS-1:0]),
      .rdata (store_rdata)
   );

   always_comb begin
      stored = s1_item_ff.need_read ? store_rdata : '0;
      for (int ch = 0; ch < CHANNELS; ch++) begin
         s2_prod_in[ch] = SUM_BITS'(stored[ch]) * SUM_BITS'(s1_item_ff.count);
         dv_sum_in[ch]  = s2_prod_ff[ch] + SUM_BITS'(s2_sample_ff[ch]);
      end
   end

   always_comb begin
      dv_step_in[0] = '0;
      for (int k = 1; k <= STEPS; k++) begin
         for (int ch = 0; ch < CHANNELS; ch++) begin
            dv_step_in[k][ch] = div_step(dv_rem_ff[k-1][ch],
                                         dv_quot_ff[k-1][ch][CHANNEL_BITS-1],
                                         dv_meta_ff[k-1].divisor);
         end
      end
   end

   always_comb begin
      logic [31:0] avg_wide;
      logic [31:0] clamped;
      for (int ch = 0; ch < CHANNELS; ch++) begin
         avg_wide      = 32'(dv_quot_ff[STEPS][ch]);
         clamped       = (avg_wide < CLAMP_Q) ? avg_wide : CLAMP_Q;
         q_prod_in[ch] = PROD_BITS'(clamped[CLAMP_BITS-1:0]) * PROD_BITS'(SCALE_Q);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         for (int k = 0; k <= STEPS; k++) begin
            dv_valid_ff[k] <= 1'b0;
         end
         q_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff    <= issue;
         s2_valid_ff    <= s1_valid_ff;
         dv_valid_ff[0] <= s2_valid_ff;
         for (int k = 1; k <= STEPS; k++) begin
            dv_valid_ff[k] <= dv_valid_ff[k-1];
         end
         q_valid_ff <= dv_valid_ff[STEPS];
      end
   end

   always_ff @(posedge clock) begin
      s1_item_ff          <= head.item;
      s2_meta_ff.idx      <= s1_item_ff.idx;
      s2_meta_ff.in_range <= s1_item_ff.in_range;
      s2_meta_ff.divisor  <= s1_item_ff.divisor;
      s2_sample_ff        <= s1_item_ff.sample;
      s2_prod_ff          <= s2_prod_in;
      dv_meta_ff[0]       <= s2_meta_ff;
      for (int ch = 0; ch < CHANNELS; ch++) begin
         dv_rem_ff[0][ch]  <= dv_sum_in[ch][SUM_BITS-1:CHANNEL_BITS];
         dv_quot_ff[0][ch] <= dv_sum_in[ch][CHANNEL_BITS-1:0];
      end
      for (int k = 1; k <= STEPS; k++) begin
         dv_meta_ff[k] <= dv_meta_ff[k-1];
         for (int ch = 0; ch < CHANNELS; ch++) begin
            dv_rem_ff[k][ch]  <= dv_step_in[k][ch][REM_BITS:1];
            dv_quot_ff[k][ch] <= {dv_quot_ff[k-1][ch][CHANNEL_BITS-2:0], dv_step_in[k][ch][0]};
         end
      end
      q_idx_ff  <= dv_meta_ff[STEPS].idx;
      q_prod_ff <= q_prod_in;
   end

   // result queue; reserved counts in-flight samples plus queued results
   assign out_entry.out_index  = q_idx_ff;
   assign out_entry.packed_rgb = {q_prod_ff[CH_RED][SCALE_SHIFT +: BYTE_BITS],
                                  q_prod_ff[CH_GREEN][SCALE_SHIFT +: BYTE_BITS],
                                  q_prod_ff[CH_BLUE][SCALE_SHIFT +: BYTE_BITS]};

   assign empty        = out_count_ff == '0;
   assign out_take     = pop && !empty;
   assign out_wr_in    = q_valid_ff ? out_wr_ff + OPTR_BITS'(1) : out_wr_ff;
   assign out_rd_in    = out_take ? out_rd_ff + OPTR_BITS'(1) : out_rd_ff;
   assign out_count_in = out_count_ff + OCNT_BITS'(q_valid_ff) - OCNT_BITS'(out_take);
   assign reserved_in  = reserved_ff + OCNT_BITS'(issue) - OCNT_BITS'(out_take);

   always_ff @(posedge clock) begin
      if (reset) begin
         out_wr_ff    <= '0;
         out_rd_ff    <= '0;
         out_count_ff <= '0;
         reserved_ff  <= '0;
      end else begin
         out_wr_ff    <= out_wr_in;
         out_rd_ff    <= out_rd_in;
         out_count_ff <= out_count_in;
         reserved_ff  <= reserved_in;
      end
   end

   always_ff @(posedge clock) begin
      if (q_valid_ff) begin
         out_ff[out_wr_ff] <= out_entry;
      end
   end

   assign rsp_data = out_ff[out_rd_ff];

endmodule

### hdl/progressive_pixel_accumulator.sv
// top level of the progressive pixel accumulator
// a sample passes the store read, multiply, divide steps and quantize before its result is queued
// throughput: one transaction per cycle while the result queue has room; a sample with nonzero frame count for a pixel
// still in the store write-back pipeline waits until that write has reached the store
// reset clears both queues and the pipeline; the average store is not cleared
module progressive_pixel_accumulator import ppa_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   output logic    full,
   input  req_type req_data,
   output logic    empty,
   input  logic    pop,
   output rsp_type rsp_data
);

   queue_head_type head;
   logic           head_pop;

   ppa_front u_front (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .full     (full),
      .req_data (req_data),
      .head     (head),
      .head_pop (head_pop)
   );

   ppa_back u_back (
      .clock    (clock),
      .reset    (reset),
      .head     (head),
      .head_pop (head_pop),
      .empty    (empty),
      .pop      (pop),
      .rsp_data (rsp_data)
   );

endmodule
